### rtl/gnc_pkg.sv
// Shared constants, types and slot ordering for the geohash neighbour code block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gnc_pkg;

	// Fixed field widths of the request and response channels.
	localparam int QUERY_W = 64;
	localparam int PREFIX_W = 7;
	localparam int COUNT_W = 4;

	// Default number of interleaved code bits.
	localparam int CODE_BITS_DEF = 64;

	// Eight neighbour slots around the centre cell.
	localparam int SLOTS = 8;
	localparam int SLOT_W = 3;

	// Row and column selectors: centre, minus one step, plus one step.
	localparam logic [1:0] SEL_CENTRE = 2'd0;
	localparam logic [1:0] SEL_MINUS = 2'd1;
	localparam logic [1:0] SEL_PLUS = 2'd2;

	// Emission order of the slots, row major, the centre cell excluded.
	localparam logic [1:0] SLOT_ROW [SLOTS] = '{
		SEL_CENTRE, SEL_CENTRE, SEL_MINUS, SEL_MINUS,
		SEL_MINUS, SEL_PLUS, SEL_PLUS, SEL_PLUS
	};
	localparam logic [1:0] SLOT_COL [SLOTS] = '{
		SEL_MINUS, SEL_PLUS, SEL_CENTRE, SEL_MINUS,
		SEL_PLUS, SEL_CENTRE, SEL_MINUS, SEL_PLUS
	};

	// Slots that trade places when all eight neighbours exist.
	localparam logic [SLOT_W-1:0] SWAP_A = 3'd3;
	localparam logic [SLOT_W-1:0] SWAP_B = 3'd5;

	// Candidate set of one request, handed from the step logic to the emitter.
	typedef struct packed {
		logic [SLOTS-1:0] slots;
		logic [COUNT_W-1:0] count;
	} cand_t;

	// Physical slot for an emission position, with the full-ring swap applied.
	function automatic logic [SLOT_W-1:0] map_slot(input logic [SLOT_W-1:0] s,
		input logic full);
		logic [SLOT_W-1:0] r;
		r = s;
		if (full && s == SWAP_A) begin
			r = SWAP_B;
		end else if (full && s == SWAP_B) begin
			r = SWAP_A;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/gnc_if.sv
// Valid/ready channel interfaces for requests and neighbour responses.
// Depends on gnc_pkg for the field widths.
`default_nettype none

interface gnc_in_if import gnc_pkg::*; ();
	logic valid;
	logic ready;
	logic [QUERY_W-1:0] query_code;
	logic [PREFIX_W-1:0] prefix_bits;

	modport source (output valid, query_code, prefix_bits, input ready);
	modport sink (input valid, query_code, prefix_bits, output ready);
endinterface

interface gnc_out_if import gnc_pkg::*; ();
	logic valid;
	logic ready;
	logic [QUERY_W-1:0] neighbor_code;
	logic neighbor_valid;
	logic [COUNT_W-1:0] neighbor_count;
	logic last;

	modport source (output valid, neighbor_code, neighbor_valid, neighbor_count, last,
		input ready);
	modport sink (input valid, neighbor_code, neighbor_valid, neighbor_count, last,
		output ready);
endinterface

`default_nettype wire

### rtl/gnc_step.sv
// Request register and the neighbour step logic: splits the code into longitude and
// latitude, steps both prefixes and marks which neighbour slots exist. Uses gnc_pkg, gnc_in_if.
`default_nettype none

module gnc_step import gnc_pkg::*; #(
	parameter int CodeBits = CODE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	gnc_in_if.sink req,
	output logic cell_valid,
	input wire logic cell_take,
	output cand_t cand,
	output logic [2:0][(CodeBits+1)/2-1:0] cols,
	output logic [2:0][CodeBits/2-1:0] rows
);

	localparam int LonW = (CodeBits + 1) / 2;
	localparam int LatW = CodeBits / 2;

	logic valid_s1;
	logic [CodeBits-1:0] code_s1;
	logic [PREFIX_W-1:0] pfx_s1;

	logic [LonW-1:0] lon;
	logic [LatW-1:0] lat;
	logic [PREFIX_W-1:0] pfx;
	logic [PREFIX_W-1:0] lon_len;
	logic [PREFIX_W-1:0] lat_len;
	logic [LonW:0] lon_unit;
	logic [LatW:0] lat_unit;
	logic [LonW:0] lon_dn;
	logic [LonW:0] lon_up;
	logic [LatW:0] lat_dn;
	logic [LatW:0] lat_up;
	logic [2:0] row_en;
	logic [2:0] col_en;
	logic [SLOTS-1:0] slots;

	// Input register; a request enters whenever the stage is empty or being drained.
	assign req.ready = !valid_s1 || cell_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			code_s1 <= req.query_code[CodeBits-1:0];
			pfx_s1 <= req.prefix_bits;
		end
	end

	// De-interleave: the top bit is longitude, then the bits alternate.
	for (genvar t = 0; t < CodeBits; t++) begin : g_split
		if (t % 2 == 0) begin : g_lon
			assign lon[LonW-1-t/2] = code_s1[CodeBits-1-t];
		end else begin : g_lat
			assign lat[LatW-1-t/2] = code_s1[CodeBits-1-t];
		end
	end

	// Prefix lengths and the weight of the lowest prefix bit of each coordinate.
	always_comb begin
		pfx = (pfx_s1 > PREFIX_W'(CodeBits)) ? PREFIX_W'(CodeBits) : pfx_s1;
		lon_len = (pfx + PREFIX_W'(1)) >> 1;
		lat_len = pfx >> 1;
		lon_unit = (LonW+1)'(1) << (PREFIX_W'(LonW) - lon_len);
		lat_unit = (LatW+1)'(1) << (PREFIX_W'(LatW) - lat_len);
	end

	// Steps on the full coordinates leave the bits below the prefix untouched.
	// Longitude wraps; a latitude step that borrows or carries out is dropped.
	always_comb begin
		lon_dn = {1'b0, lon} - lon_unit;
		lon_up = {1'b0, lon} + lon_unit;
		lat_dn = {1'b0, lat} - lat_unit;
		lat_up = {1'b0, lat} + lat_unit;

		cols[SEL_CENTRE] = lon;
		cols[SEL_MINUS] = lon_dn[LonW-1:0];
		cols[SEL_PLUS] = lon_up[LonW-1:0];

		rows[SEL_CENTRE] = lat;
		rows[SEL_MINUS] = lat_dn[LatW] ? lat : lat_dn[LatW-1:0];
		rows[SEL_PLUS] = lat_up[LatW] ? rows[SEL_MINUS] : lat_up[LatW-1:0];
	end

	// A row or column equal to the one before it is skipped.
	always_comb begin
		row_en[SEL_CENTRE] = 1'b1;
		row_en[SEL_MINUS] = rows[SEL_MINUS] != rows[SEL_CENTRE];
		row_en[SEL_PLUS] = rows[SEL_PLUS] != rows[SEL_MINUS];
		col_en[SEL_CENTRE] = 1'b1;
		col_en[SEL_MINUS] = cols[SEL_MINUS] != cols[SEL_CENTRE];
		col_en[SEL_PLUS] = cols[SEL_PLUS] != cols[SEL_MINUS];
		for (int k = 0; k < SLOTS; k++) begin
			slots[k] = row_en[SLOT_ROW[k]] & col_en[SLOT_COL[k]];
		end
		cand.slots = slots;
		cand.count = COUNT_W'($countones(slots));
	end

	assign cell_valid = valid_s1;

endmodule

`default_nettype wire

### rtl/gnc_emit.sv
// Neighbour emitter: holds one request's candidate set and sends one response per
// cycle, when rsp.ready allows, through a registered response stage. Uses gnc_pkg and gnc_out_if.
`default_nettype none

module gnc_emit import gnc_pkg::*; #(
	parameter int CodeBits = CODE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cell_valid,
	output logic cell_take,
	input cand_t cand,
	input wire logic [2:0][(CodeBits+1)/2-1:0] cols,
	input wire logic [2:0][CodeBits/2-1:0] rows,
	gnc_out_if.source rsp
);

	localparam int LonW = (CodeBits + 1) / 2;
	localparam int LatW = CodeBits / 2;

	logic valid_s2;
	logic [SLOTS-1:0] rem_s2;
	logic [COUNT_W-1:0] count_s2;
	logic [2:0][LonW-1:0] cols_s2;
	logic [2:0][LatW-1:0] rows_s2;

	logic valid_s3;
	logic [QUERY_W-1:0] code_s3;
	logic nvalid_s3;
	logic [COUNT_W-1:0] count_s3;
	logic last_s3;

	logic out_free;
	logic emit;
	logic [SLOT_W-1:0] pick;
	logic [SLOT_W-1:0] slot;
	logic [SLOTS-1:0] rem_next;
	logic none;
	logic last_pick;
	logic [LonW-1:0] col_sel;
	logic [LatW-1:0] row_sel;
	logic [CodeBits-1:0] code_w;

	// Response stage is free when empty or when its response is being taken.
	assign out_free = !valid_s3 || rsp.ready;
	assign emit = valid_s2 && out_free;

	// Lowest remaining slot goes next.
	always_comb begin
		pick = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (rem_s2[k]) begin
				pick = SLOT_W'(k);
			end
		end
		rem_next = rem_s2 & ~(SLOTS'(1) << pick);
		none = count_s2 == '0;
		last_pick = none || rem_next == '0;
		slot = map_slot(pick, count_s2 == COUNT_W'(SLOTS));
		col_sel = cols_s2[SLOT_COL[slot]];
		row_sel = rows_s2[SLOT_ROW[slot]];
	end

	// Re-interleave the chosen column and row into a full code.
	for (genvar t = 0; t < CodeBits; t++) begin : g_merge
		if (t % 2 == 0) begin : g_lon
			assign code_w[CodeBits-1-t] = col_sel[LonW-1-t/2];
		end else begin : g_lat
			assign code_w[CodeBits-1-t] = row_sel[LatW-1-t/2];
		end
	end

	// A new candidate set is taken when the held one sends its final response.
	assign cell_take = !valid_s2 || (emit && last_pick);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (cell_take) begin
				valid_s2 <= cell_valid;
			end
			if (out_free) begin
				valid_s3 <= emit;
			end
		end
	end

	// Candidate hold register and its shrinking slot mask.
	always_ff @(posedge clk) begin
		if (cell_take && cell_valid) begin
			rem_s2 <= cand.slots;
			count_s2 <= cand.count;
			cols_s2 <= cols;
			rows_s2 <= rows;
		end else if (emit) begin
			rem_s2 <= rem_next;
		end
	end

	// Response register; a request with no neighbours sends one empty response.
	always_ff @(posedge clk) begin
		if (emit) begin
			code_s3 <= none ? '0 : QUERY_W'(code_w);
			nvalid_s3 <= !none;
			count_s3 <= count_s2;
			last_s3 <= last_pick;
		end
	end

	assign rsp.valid = valid_s3;
	assign rsp.neighbor_code = code_s3;
	assign rsp.neighbor_valid = nvalid_s3;
	assign rsp.neighbor_count = count_s3;
	assign rsp.last = last_s3;

endmodule

`default_nettype wire

### rtl/geohash_neighbor_codes_core.sv
// Top level of the geohash neighbour code block: step logic followed by the emitter.
// Depends on gnc_pkg, gnc_if, gnc_step and gnc_emit.
//
//   channel | dir | fields                                                 | handshake
//   req     | in  | query_code[63:0], prefix_bits[6:0]                     | valid/ready
//   rsp     | out | neighbor_code[63:0], neighbor_valid, neighbor_count[3:0], last | valid/ready
//
// Each request yields max(n, 1) responses, n the neighbour count (0 to 8), sent one per
// cycle from the response register while rsp.ready is high; a request passes through the
// request register, the candidate hold register and the response register in that order.
// The request register and the candidate hold register let the next request enter while
// the current one is still being sent. Reset clears only the stage valid flags.
// When rsp.ready is low the response register holds and the stages behind it fill up.
`default_nettype none

module geohash_neighbor_codes_core import gnc_pkg::*; #(
	parameter int CodeBits = CODE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	gnc_in_if.sink req,
	gnc_out_if.source rsp
);

	localparam int LonW = (CodeBits + 1) / 2;
	localparam int LatW = CodeBits / 2;

	logic cell_valid;
	logic cell_take;
	cand_t cand;
	logic [2:0][LonW-1:0] cols;
	logic [2:0][LatW-1:0] rows;

	// Split, step and mark the neighbour slots of one request.
	gnc_step #(
		.CodeBits(CodeBits)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cell_valid(cell_valid),
		.cell_take(cell_take),
		.cand(cand),
		.cols(cols),
		.rows(rows)
	);

	// Send the neighbours one by one.
	gnc_emit #(
		.CodeBits(CodeBits)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.cell_valid(cell_valid),
		.cell_take(cell_take),
		.cand(cand),
		.cols(cols),
		.rows(rows),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

### verif/tb_geohash_neighbor_codes_core.sv
// Self-checking testbench for geohash_neighbor_codes_core: drives query requests,
// predicts every neighbour code and checks each response in order.
// Depends on gnc_pkg, the gnc_in_if / gnc_out_if interfaces and the block's RTL.
`default_nettype none

module tb_geohash_neighbor_codes_core;
	timeunit 1ns;
	timeprecision 1ps;

	import gnc_pkg::*;

	// Run limits and stall lengths, in clock cycles.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	// Interleaved bit positions: longitude on odd bits, latitude on even bits.
	localparam logic [QUERY_W-1:0] LON_BITS = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [QUERY_W-1:0] LAT_BITS = 64'h5555_5555_5555_5555;

	// One expected response of the block.
	typedef struct packed {
		logic [QUERY_W-1:0] code;
		logic present;
		logic [COUNT_W-1:0] count;
		logic last_flag;
	} nbr_result_t;

	logic clk;
	logic arst_n;
	int send_idle_pct = 20;
	int recv_idle_pct = 53;
	int mismatches = 0;
	int stalled_cycles = 0;
	logic rsp_holding;
	event rsp_hold_go;
	nbr_result_t pending_neighbours[$];

	gnc_in_if req_if();
	gnc_out_if rsp_if();

	geohash_neighbor_codes_core #(
		.CodeBits(CODE_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Free-running clock, 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out every neighbour of one query and queue the responses it should cause.
	function automatic void predict_neighbours(input logic [QUERY_W-1:0] q,
		input logic [PREFIX_W-1:0] p_raw);
		int unsigned p, lon_len, lat_len, n, t, i, j;
		logic [QUERY_W-1:0] lon, lat, lon_m, lat_m, code, swap;
		logic [QUERY_W-1:0] cols [3];
		logic [QUERY_W-1:0] rows [3];
		logic [QUERY_W-1:0] found [SLOTS];
		nbr_result_t r;
		p = (p_raw > CODE_BITS_DEF) ? CODE_BITS_DEF : p_raw;
		lon_len = (p + 1) / 2;
		lat_len = p / 2;
		lon = '0;
		lat = '0;
		n = 0;
		// Split the prefix into its longitude and latitude halves, MSB first.
		for (t = 0; t < p; t++) begin
			if (t % 2 == 0) begin
				lon = {lon[QUERY_W-2:0], q[CODE_BITS_DEF-1-t]};
			end else begin
				lat = {lat[QUERY_W-2:0], q[CODE_BITS_DEF-1-t]};
			end
		end
		lon_m = (64'd1 << lon_len) - 64'd1;
		lat_m = (64'd1 << lat_len) - 64'd1;
		// Longitude wraps; a latitude step past either pole is dropped.
		cols[0] = lon;
		cols[1] = (lon - 64'd1) & lon_m;
		cols[2] = (lon + 64'd1) & lon_m;
		rows[0] = lat;
		rows[1] = (lat_len == 0 || lat == 0) ? lat : lat - 64'd1;
		rows[2] = (lat_len == 0 || lat == lat_m) ? rows[1] : lat + 64'd1;
		// Visit rows then columns, skipping repeats and the centre cell.
		for (i = 0; i < 3; i++) begin
			if (i > 0 && rows[i-1] == rows[i]) continue;
			for (j = 0; j < 3; j++) begin
				if (j > 0 && cols[j-1] == cols[j]) continue;
				if (i == 0 && j == 0) continue;
				code = q;
				for (t = 0; t < p; t++) begin
					if (t % 2 == 0) begin
						code[CODE_BITS_DEF-1-t] = cols[j][lon_len-1-t/2];
					end else begin
						code[CODE_BITS_DEF-1-t] = rows[i][lat_len-1-t/2];
					end
				end
				found[n] = code;
				n++;
			end
		end
		// A full ring of eight trades two of its entries.
		if (n == SLOTS) begin
			swap = found[SWAP_A];
			found[SWAP_A] = found[SWAP_B];
			found[SWAP_B] = swap;
		end
		if (n == 0) begin
			r.code = '0;
			r.present = 1'b0;
			r.count = '0;
			r.last_flag = 1'b1;
			pending_neighbours.push_back(r);
		end else begin
			for (i = 0; i < n; i++) begin
				r.code = found[i];
				r.present = 1'b1;
				r.count = n[COUNT_W-1:0];
				r.last_flag = (i + 1 == n);
				pending_neighbours.push_back(r);
			end
		end
	endfunction

	// Random query, biased towards cells on the poles and the longitude seam.
	function automatic void pick_random_query(output logic [QUERY_W-1:0] q,
		output logic [PREFIX_W-1:0] p);
		q = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: q = q | LAT_BITS;
			1: q = q & ~LAT_BITS;
			2: q = q | LON_BITS;
			3: q = q & ~LON_BITS;
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0) begin
			p = PREFIX_W'($urandom_range(CODE_BITS_DEF + 1, 127));
		end else begin
			p = PREFIX_W'($urandom_range(0, CODE_BITS_DEF));
		end
	endfunction

	function automatic void check_field(input string field, input logic [QUERY_W-1:0] want,
		input logic [QUERY_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Offer one request, with random idle cycles ahead of it, and wait until it is taken.
	// Valid is left high so that back-to-back requests need no second assignment.
	task automatic send_query(input logic [QUERY_W-1:0] q, input logic [PREFIX_W-1:0] p);
		logic took;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.query_code <= q;
		req_if.prefix_bits <= p;
		do begin
			@(negedge clk);
			took = req_if.ready;
			if (took) predict_neighbours(q, p);
			@(posedge clk);
		end while (!took);
	endtask

	// Stop offering requests and wait until every expected response has arrived.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_neighbours.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Extremes of both fields, poles, the longitude seam and prefix saturation.
	task automatic test_directed_cases();
		send_query(64'h0123_4567_89AB_CDEF, 7'd0);
		send_query(64'h0, 7'd1);
		send_query(64'hFFFF_FFFF_FFFF_FFFF, 7'd1);
		send_query(64'h0, 7'd2);
		send_query(64'hFFFF_FFFF_FFFF_FFFF, 7'd2);
		send_query(64'h0, 7'd3);
		send_query(64'h0, 7'd64);
		send_query(64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
		send_query(LAT_BITS, 7'd64);
		send_query(LON_BITS, 7'd64);
		send_query(64'h0123_4567_89AB_CDEF, 7'd64);
		send_query(64'h0123_4567_89AB_CDEF, 7'd63);
		send_query(64'hFEDC_BA98_7654_3210, 7'd65);
		send_query(64'hFEDC_BA98_7654_3210, 7'd127);
		send_query(64'h6A5C_3E17_92B4_D0F1, 7'd33);
		send_query(64'h6A5C_3E17_92B4_D0F1, 7'd4);
		send_query(64'h8000_0000_0000_0001, 7'd64);
	endtask

	task automatic test_random_traffic(input int count, input int send_pct,
		input int recv_pct);
		logic [QUERY_W-1:0] q;
		logic [PREFIX_W-1:0] p;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			pick_random_query(q, p);
			send_query(q, p);
		end
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_output_stall();
		logic [QUERY_W-1:0] q;
		logic [PREFIX_W-1:0] p;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> rsp_hold_go;
		repeat (40) begin
			pick_random_query(q, p);
			send_query(q, p);
		end
	endtask

	// The sender pauses until the block has emptied, then resumes.
	task automatic test_drain_pause();
		logic [QUERY_W-1:0] q;
		logic [PREFIX_W-1:0] p;
		repeat (2) begin
			repeat (12) begin
				pick_random_query(q, p);
				send_query(q, p);
			end
			wait_drained();
		end
	endtask

	// Response ready: random idling, or held low during a long stall.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= !rsp_holding && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Long receiver stall, counted here so the sender carries on meanwhile.
	initial begin
		rsp_holding = 1'b0;
		forever begin
			@(rsp_hold_go);
			rsp_holding <= 1'b1;
			repeat (RSP_HOLD_CYCLES) @(posedge clk);
			rsp_holding <= 1'b0;
		end
	end

	// Compare each response taken at the coming edge with the oldest expectation.
	always @(negedge clk) begin
		nbr_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_neighbours.size() == 0) begin
				$display("%0t ns: unexpected response: expected none, actual code %h",
					$time, rsp_if.neighbor_code);
				mismatches++;
			end else begin
				want = pending_neighbours.pop_front();
				check_field("neighbor_code", want.code, rsp_if.neighbor_code);
				check_field("neighbor_valid", QUERY_W'(want.present),
					QUERY_W'(rsp_if.neighbor_valid));
				check_field("neighbor_count", QUERY_W'(want.count),
					QUERY_W'(rsp_if.neighbor_count));
				check_field("last", QUERY_W'(want.last_flag), QUERY_W'(rsp_if.last));
			end
		end
	end

	// Watchdog: too long without any request or response moving ends the run.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				stalled_cycles <= 0;
			end else if (stalled_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t ns: timeout, nothing moved for %0d cycles", $time,
					WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
		end
	end

	// Reset once, then run the tests in turn.
	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.query_code = '0;
		req_if.prefix_bits = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(120, 20, 53);
		test_output_stall();
		test_random_traffic(120, 53, 20);
		test_drain_pause();
		test_random_traffic(120, 0, 0);
		wait_drained();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
